@@ src/isss_pkg.sv @@
// Package for the indexed shift stack: default sizes, field widths,
// operation and status codes, and the command that is broadcast to the cells.
// It has no dependencies.
`default_nettype none

package isss_pkg;

	localparam int ISSS_DEPTH      = 16;
	localparam int ISSS_DATA_WIDTH = 32;

	// The limit register is four bits wide, so no more than sixteen entries are ever held.
	localparam int MAX_CAP = 16;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 5;
	localparam int CNT_W   = 5;
	localparam int STAT_W  = 2;
	localparam int LIMIT_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 4'd15;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 3'd0,
		FN_POP    = 3'd1,
		FN_INSERT = 3'd2,
		FN_REMOVE = 3'd3,
		FN_CHANGE = 3'd4,
		FN_GET    = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CO_HOLD,
		CO_WRITE,
		CO_INSERT,
		CO_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ src/isss_cell.sv @@
// One storage cell of the indexed shift stack. It holds one word and takes
// a new word, its lower neighbour or its upper neighbour as the command asks.
// Depends on isss_pkg.
`default_nettype none

module isss_cell #(
	parameter int DATA_WIDTH = isss_pkg::ISSS_DATA_WIDTH,
	parameter int IDX        = 0
) (
	input  wire                     clk,
	input  wire isss_pkg::cell_ctl_t ctl,
	input  wire  [DATA_WIDTH-1:0]   word_in,
	input  wire  [DATA_WIDTH-1:0]   lower,
	input  wire  [DATA_WIDTH-1:0]   upper,
	output logic [DATA_WIDTH-1:0]   value
);
	import isss_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [DATA_WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CO_WRITE: begin
				if (ctl.pos == MY_POS) value_q <= word_in;
			end
			CO_INSERT: begin
				if (ctl.pos == MY_POS) value_q <= word_in;
				else if (MY_POS > ctl.pos) value_q <= lower;
			end
			CO_REMOVE: begin
				if (MY_POS >= ctl.pos) value_q <= upper;
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;

endmodule

`default_nettype wire

@@ src/indexed_shift_stack_core.sv @@
// Indexed shift stack: a stack of words, held in a row of shifting cells.
// Depends on isss_pkg and isss_cell.
//
// Usage. An item on the input channel (in_valid, in_stall) carries an
// operation in func, an index in position and a word in word_in. Push and
// pop work at the top; insert shifts the cells above the index up and
// remove the cells from the index on down, by one place; change overwrites
// and get reads one entry. Each item gives one result item on the output
// channel (out_valid, out_stall) with status, word_out and entry_count.
// The result appears in the output register on the cycle after the item
// is accepted. Throughput is one item per cycle while the receiver does
// not stall, as the cell row shifts at once behind one output register.
// While the receiver stalls a waiting result, in_stall is raised and the
// result is held. Reset clears the count, empties the output register and
// sets stack_limit to 15; the cell contents are not cleared. The capacity
// is the smaller of stack_limit + 1 and DEPTH, at most 16. cfg_wr_en writes
// stack_limit; the user must do so only while idle, which is not enforced.
`default_nettype none

module indexed_shift_stack_core #(
	parameter int DEPTH      = isss_pkg::ISSS_DEPTH,
	parameter int DATA_WIDTH = isss_pkg::ISSS_DATA_WIDTH
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wr_en,
	input  wire  [isss_pkg::LIMIT_W-1:0]    cfg_wr_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [isss_pkg::FUNC_W-1:0]     func,
	input  wire  [isss_pkg::POS_W-1:0]      position,
	input  wire  [DATA_WIDTH-1:0]           word_in,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [isss_pkg::STAT_W-1:0]     status,
	output logic [DATA_WIDTH-1:0]           word_out,
	output logic [isss_pkg::CNT_W-1:0]      entry_count
);
	import isss_pkg::*;

	localparam int CELLS = (DEPTH < MAX_CAP) ? DEPTH : MAX_CAP;
	localparam logic [CNT_W-1:0] CELLS_CNT = CNT_W'(CELLS);

	logic [LIMIT_W-1:0]    limit_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [DATA_WIDTH-1:0] word_out_q;
	logic [CNT_W-1:0]      entry_count_q;

	logic                  accept;
	logic                  full;
	cell_op_t              op;
	cell_ctl_t             ctl;
	logic [POS_W-1:0]      cmd_pos;
	status_t               st_d;
	logic [CNT_W-1:0]      cnt_d;
	logic [POS_W-1:0]      rd_idx;
	logic                  rd_en;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [DATA_WIDTH-1:0] word_d;
	logic [DATA_WIDTH-1:0] cell_val [CELLS];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q > CNT_W'(limit_q)) || (count_q >= CELLS_CNT);

	always_comb begin
		op      = CO_HOLD;
		cmd_pos = position;
		st_d    = ST_OK;
		cnt_d   = count_q;
		rd_idx  = position;
		rd_en   = 1'b0;
		unique case (func_t'(func))
			FN_PUSH: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					op      = CO_INSERT;
					cmd_pos = count_q;
					cnt_d   = count_q + CNT_W'(1);
				end
			end
			FN_POP: begin
				if (count_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					rd_idx = count_q - CNT_W'(1);
					rd_en  = 1'b1;
					cnt_d  = count_q - CNT_W'(1);
				end
			end
			FN_INSERT: begin
				if (full) begin
					st_d = ST_FULL;
				end else if (position > count_q) begin
					st_d = ST_RANGE;
				end else begin
					op    = CO_INSERT;
					cnt_d = count_q + CNT_W'(1);
				end
			end
			FN_REMOVE: begin
				if (position >= count_q) begin
					st_d = ST_RANGE;
				end else begin
					op    = CO_REMOVE;
					rd_en = 1'b1;
					cnt_d = count_q - CNT_W'(1);
				end
			end
			FN_CHANGE: begin
				if (position >= count_q) st_d = ST_RANGE;
				else op = CO_WRITE;
			end
			FN_GET: begin
				if (position >= count_q) st_d = ST_RANGE;
				else rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ctl.op  = accept ? op : CO_HOLD;
	assign ctl.pos = cmd_pos;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (i == 0) begin : g_bottom
			assign lower = cell_val[i];
		end else begin : g_lower
			assign lower = cell_val[i-1];
		end
		if (i == CELLS - 1) begin : g_top
			assign upper = cell_val[i];
		end else begin : g_upper
			assign upper = cell_val[i+1];
		end
		isss_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.word_in (word_in),
			.lower   (lower),
			.upper   (upper),
			.value   (cell_val[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (rd_idx == POS_W'(i)) rd_word = cell_val[i];
		end
	end

	assign word_d = rd_en ? rd_word : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RST;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (accept) begin
				count_q     <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= st_d;
			word_out_q    <= word_d;
			entry_count_q <= cnt_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign word_out    = word_out_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

@@ src/isss_checker.sv @@
// Port-level checks for the indexed shift stack, and the bind that attaches
// them to indexed_shift_stack_core. Depends on isss_pkg.
`default_nettype none

module isss_checker #(
	parameter int DATA_WIDTH = isss_pkg::ISSS_DATA_WIDTH
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_stall,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire [isss_pkg::STAT_W-1:0]   status,
	input wire [DATA_WIDTH-1:0]         word_out,
	input wire [isss_pkg::CNT_W-1:0]    entry_count
);
	import isss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(word_out) && $stable(entry_count))
		else $error("Stalled result item changed.");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("Input stall does not follow the output stall.");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(MAX_CAP))
		else $error("Entry count beyond capacity.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0)
		else $error("Empty status with entries present.");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> word_out == '0)
		else $error("Refused item returned a word.");

endmodule

bind indexed_shift_stack_core isss_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_isss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.word_out    (word_out),
	.entry_count (entry_count)
);

`default_nettype wire
